FILE: hw/rtl/escd_pkg.sv
`default_nettype none

package escd_pkg;

   // Most results that one input word can cause.
   localparam int MaxRes = 3;
   localparam int ResIdxW = $clog2(MaxRes + 1);

   // Default depth of the queue between the front and back parts.
   localparam int QueueDepth = 4;

   // Character codes used by the decoder.
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChQuote     = 8'h27;
   localparam logic [7:0] ChDquote    = 8'h22;
   localparam logic [7:0] ChNewline   = 8'h0A;
   localparam logic [7:0] ChZero      = 8'h30;
   localparam logic [7:0] ChSeven     = 8'h37;
   localparam logic [7:0] ChNine      = 8'h39;
   localparam logic [7:0] ChLowA      = 8'h61;
   localparam logic [7:0] ChLowB      = 8'h62;
   localparam logic [7:0] ChLowF      = 8'h66;
   localparam logic [7:0] ChLowN      = 8'h6E;
   localparam logic [7:0] ChLowR      = 8'h72;
   localparam logic [7:0] ChLowT      = 8'h74;
   localparam logic [7:0] ChLowV      = 8'h76;
   localparam logic [7:0] ChLowX      = 8'h78;
   localparam logic [7:0] ChUpA       = 8'h41;
   localparam logic [7:0] ChUpF       = 8'h46;

   // Control codes produced by the named escapes.
   localparam logic [7:0] CodeBell     = 8'h07;
   localparam logic [7:0] CodeBackspc  = 8'h08;
   localparam logic [7:0] CodeFormfeed = 8'h0C;
   localparam logic [7:0] CodeNewline  = 8'h0A;
   localparam logic [7:0] CodeReturn   = 8'h0D;
   localparam logic [7:0] CodeTab      = 8'h09;
   localparam logic [7:0] CodeVtab     = 8'h0B;

   // All results caused by one input word, as one queue entry.
   typedef struct packed {
      logic [ResIdxW-1:0]          cnt;
      logic                        str_end;
      logic [MaxRes-1:0][7:0]      res_data;
      logic [MaxRes-1:0]           res_err;
   } bundle_type;

   // Hexadecimal digit decode: bit 4 is the valid flag, bits 3:0 the value.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= ChZero && c <= ChNine) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= ChLowA && c <= ChLowF) || (c >= ChUpA && c <= ChUpF)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic is_octal(input logic [7:0] c);
      return (c >= ChZero) && (c <= ChSeven);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/escd_front.sv
`default_nettype none

module escd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic                 csr_raw_mode,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_in_byte,
   input  wire logic                 req_in_last,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output escd_pkg::bundle_type      push_data
);

   localparam logic [2:0] ModeText = 3'd0;
   localparam logic [2:0] ModeEsc  = 3'd1;
   localparam logic [2:0] ModeOct  = 3'd2;
   localparam logic [2:0] ModeHex0 = 3'd3;
   localparam logic [2:0] ModeHex1 = 3'd4;

   logic       raw_mode_ff;
   logic [2:0] mode_ff, mode_in;
   logic [8:0] acc_ff, acc_in;
   logic [1:0] digits_ff, digits_in;
   logic [7:0] held_ff, held_in;

   escd_pkg::bundle_type bund;
   logic                 do_text;
   logic                 accept;
   logic [4:0]           hv_cur;
   logic [4:0]           hv_held;
   logic [1:0]           digits_inc;

   // Appends one result to a bundle.
   function automatic escd_pkg::bundle_type push(input escd_pkg::bundle_type b,
                                                 input logic [7:0] d,
                                                 input logic e);
      escd_pkg::bundle_type r;
      r = b;
      r.res_data[r.cnt] = e ? 8'h00 : d;
      r.res_err[r.cnt]  = e;
      r.cnt             = r.cnt + escd_pkg::ResIdxW'(1);
      return r;
   endfunction

   assign accept     = req_valid && req_ready;
   assign req_ready  = push_ready;
   assign hv_cur     = escd_pkg::hex_value(req_in_byte);
   assign hv_held    = escd_pkg::hex_value(held_ff);
   assign digits_inc = digits_ff + 2'd1;

   // Classify the word against the decode state and gather its results.
   always_comb begin
      bund     = '0;
      do_text  = 1'b0;
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      digits_in = digits_ff;
      held_in  = held_ff;

      if (raw_mode_ff) begin
         mode_in = ModeText;
         bund    = push(bund, req_in_byte, 1'b0);
      end else begin
         unique case (mode_ff)
            ModeEsc: begin
               mode_in = ModeText;
               unique case (req_in_byte) inside
                  escd_pkg::ChNewline: ;
                  escd_pkg::ChLowA: bund = push(bund, escd_pkg::CodeBell, 1'b0);
                  escd_pkg::ChLowB: bund = push(bund, escd_pkg::CodeBackspc, 1'b0);
                  escd_pkg::ChLowF: bund = push(bund, escd_pkg::CodeFormfeed, 1'b0);
                  escd_pkg::ChLowN: bund = push(bund, escd_pkg::CodeNewline, 1'b0);
                  escd_pkg::ChLowR: bund = push(bund, escd_pkg::CodeReturn, 1'b0);
                  escd_pkg::ChLowT: bund = push(bund, escd_pkg::CodeTab, 1'b0);
                  escd_pkg::ChLowV: bund = push(bund, escd_pkg::CodeVtab, 1'b0);
                  escd_pkg::ChQuote, escd_pkg::ChDquote, escd_pkg::ChBackslash: begin
                     bund = push(bund, req_in_byte, 1'b0);
                  end
                  escd_pkg::ChLowX: begin
                     if (req_in_last) begin
                        bund = push(bund, 8'h00, 1'b1);
                     end else begin
                        mode_in = ModeHex0;
                     end
                  end
                  default: begin
                     if (escd_pkg::is_octal(req_in_byte)) begin
                        acc_in    = {6'd0, req_in_byte[2:0]};
                        digits_in = 2'd1;
                        if (req_in_last) begin
                           bund = push(bund, {5'd0, req_in_byte[2:0]}, 1'b0);
                        end else begin
                           mode_in = ModeOct;
                        end
                     end else begin
                        bund = push(bund, escd_pkg::ChBackslash, 1'b0);
                        bund = push(bund, req_in_byte, 1'b0);
                     end
                  end
               endcase
            end
            ModeOct: begin
               if (escd_pkg::is_octal(req_in_byte) && digits_ff != 2'd3) begin
                  acc_in    = {acc_ff[5:0], req_in_byte[2:0]};
                  digits_in = digits_inc;
                  if (digits_inc == 2'd3 || req_in_last) begin
                     bund    = push(bund, acc_in[7:0], 1'b0);
                     mode_in = ModeText;
                  end
               end else begin
                  bund    = push(bund, acc_ff[7:0], 1'b0);
                  do_text = 1'b1;
               end
            end
            ModeHex0: begin
               if (hv_cur[4] && !req_in_last) begin
                  held_in = req_in_byte;
                  mode_in = ModeHex1;
               end else begin
                  bund    = push(bund, 8'h00, 1'b1);
                  do_text = 1'b1;
               end
            end
            ModeHex1: begin
               if (hv_cur[4]) begin
                  bund    = push(bund, {hv_held[3:0], hv_cur[3:0]}, 1'b0);
                  mode_in = ModeText;
               end else begin
                  bund    = push(bund, 8'h00, 1'b1);
                  bund    = push(bund, held_ff, 1'b0);
                  do_text = 1'b1;
               end
            end
            default: begin
               do_text = 1'b1;
            end
         endcase

         // Plain text handling of the current word.
         if (do_text) begin
            if (req_in_byte == escd_pkg::ChBackslash && !req_in_last) begin
               mode_in = ModeEsc;
            end else begin
               mode_in = ModeText;
               bund    = push(bund, req_in_byte, 1'b0);
            end
         end
      end

      // Side state only lives while its mode does.
      if (mode_in != ModeOct) begin
         acc_in    = '0;
         digits_in = '0;
      end
      if (mode_in != ModeHex1) begin
         held_in = '0;
      end
      if (req_in_last) begin
         mode_in   = ModeText;
         acc_in    = '0;
         digits_in = '0;
         held_in   = '0;
      end

      bund.str_end = req_in_last;
   end

   // Only words that cause at least one result enter the queue.
   assign push_valid = req_valid && (bund.cnt != '0);
   assign push_data  = bund;

   // Decode state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff <= 1'b0;
         mode_ff     <= ModeText;
         acc_ff      <= '0;
         digits_ff   <= '0;
         held_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            raw_mode_ff <= csr_raw_mode;
         end
         if (accept) begin
            mode_ff   <= mode_in;
            acc_ff    <= acc_in;
            digits_ff <= digits_in;
            held_ff   <= held_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/escd_queue.sv
`default_nettype none

module escd_queue #(
   parameter int Depth = escd_pkg::QueueDepth
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire escd_pkg::bundle_type push_data,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output escd_pkg::bundle_type      pop_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   escd_pkg::bundle_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/escd_back.sv
`default_nettype none

module escd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  wire escd_pkg::bundle_type pop_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_is_error,
   output logic                      rsp_run_last,
   output logic                      rsp_string_end
);

   logic [escd_pkg::ResIdxW-1:0] idx_ff;
   logic                         valid_ff;
   logic [7:0]                   byte_ff;
   logic                         err_ff, run_last_ff, str_end_ff;
   logic                         load, is_final;

   // The output register takes a new result when empty or being drained.
   assign load      = pop_valid && (!valid_ff || rsp_ready);
   assign is_final  = (idx_ff == pop_data.cnt - escd_pkg::ResIdxW'(1));
   assign pop_ready = load && is_final;

   // Result index within the head entry and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff   <= is_final ? '0 : idx_ff + escd_pkg::ResIdxW'(1);
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Output word payload.
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= pop_data.res_data[idx_ff];
         err_ff      <= pop_data.res_err[idx_ff];
         run_last_ff <= is_final;
         str_end_ff  <= is_final && pop_data.str_end;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_is_error   = err_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_string_end = str_end_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/string_escape_decoder_core.sv
// Input path: an accepted word is written into the queue, then into the output register.
// Throughput: one input word per cycle while the queue has room; the results of one word
// leave the output one after another, the queue between the decode and output parts absorbing the burst.
// The output register delivers at most one result word per cycle.
// Reset is synchronous and active high: it clears the decode state, raw mode, the queue and the output valid.
`default_nettype none

module string_escape_decoder_core #(
   parameter int QueueDepth = escd_pkg::QueueDepth
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_raw_mode,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_error,
   output logic            rsp_run_last,
   output logic            rsp_string_end
);

   logic                 push_valid, push_ready;
   logic                 pop_valid, pop_ready;
   escd_pkg::bundle_type push_data, pop_data;

   // Front part: decode state machine.
   escd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_raw_mode (csr_raw_mode),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data)
   );

   // Queue of result groups.
   escd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back part: serialises results onto the output channel.
   escd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_error   (rsp_is_error),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule

`default_nettype wire

FILE: dv/string_escape_decoder_core_tb.sv
`timescale 1ns / 100ps

module string_escape_decoder_core_tb;

   // Decoder state, kept alongside the block.
   typedef enum logic [2:0] {
      DEC_TEXT,
      DEC_ESC,
      DEC_OCT,
      DEC_HEX0,
      DEC_HEX1
   } dec_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } lit_byte_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_error;
      logic       run_last;
      logic       string_end;
   } decoded_type;

   localparam int WdLimit   = 2000;
   localparam int DrainWait = 8;

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       csr_wr_en    = 1'b0;
   logic       csr_raw_mode = 1'b0;
   logic       req_valid    = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte  = 8'h00;
   logic       req_in_last  = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready    = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_error;
   logic       rsp_run_last;
   logic       rsp_string_end;

   // Stimulus and expectation stores.
   lit_byte_type lit_bytes_q[$];
   decoded_type  decoded_q[$];
   decoded_type  step_res[$];

   // Predicted decoder state and the copy of the raw mode register.
   dec_mode_type dec_mode = DEC_TEXT;
   logic [8:0] oct_acc  = '0;
   logic [1:0] oct_cnt  = '0;
   logic [7:0] hex_held = '0;
   logic       raw_q    = 1'b0;

   logic       req_hs     = 1'b0;
   int         stall_pct  = 20;
   int         n_queued   = 0;
   int         n_accepted = 0;
   int         n_checked  = 0;
   int         n_err_res  = 0;
   int         n_str_end  = 0;
   int         fail_cnt   = 0;
   int         wd_cnt     = 0;

   string_escape_decoder_core dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_raw_mode   (csr_raw_mode),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_error   (rsp_is_error),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hex digit value with a valid flag in bit 4; zero for anything else.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      if (c >= escd_pkg::ChZero && c <= escd_pkg::ChNine) begin
         d = c - escd_pkg::ChZero;
      end else if (c >= escd_pkg::ChLowA && c <= escd_pkg::ChLowF) begin
         d = c - escd_pkg::ChLowA + 8'd10;
      end else if (c >= escd_pkg::ChUpA && c <= escd_pkg::ChUpF) begin
         d = c - escd_pkg::ChUpA + 8'd10;
      end else begin
         return 5'd0;
      end
      return {1'b1, d[3:0]};
   endfunction

   function automatic logic is_oct_digit(input logic [7:0] c);
      return c >= escd_pkg::ChZero && c <= escd_pkg::ChSeven;
   endfunction

   function automatic void push_decoded(input logic [7:0] v, input logic err);
      decoded_type r;
      r.out_byte   = err ? 8'h00 : v;
      r.is_error   = err;
      r.run_last   = 1'b0;
      r.string_end = 1'b0;
      step_res.push_back(r);
   endfunction

   // A byte met in plain text: a backslash opens an escape unless it ends the literal.
   function automatic void decode_text(input logic [7:0] b, input logic last);
      if (b == escd_pkg::ChBackslash) begin
         if (last) begin
            push_decoded(escd_pkg::ChBackslash, 1'b0);
         end else begin
            dec_mode = DEC_ESC;
         end
      end else begin
         dec_mode = DEC_TEXT;
         push_decoded(b, 1'b0);
      end
   endfunction

   // Works out the results of one accepted input word and queues them.
   function automatic void decode_word(input logic [7:0] b, input logic last);
      logic [4:0] hv;
      logic [4:0] hh;
      step_res.delete();
      if (raw_q) begin
         dec_mode = DEC_TEXT;
         push_decoded(b, 1'b0);
      end else begin
         case (dec_mode)
            DEC_ESC: begin
               dec_mode = DEC_TEXT;
               case (b) inside
                  escd_pkg::ChNewline: ;
                  escd_pkg::ChLowA: push_decoded(escd_pkg::CodeBell, 1'b0);
                  escd_pkg::ChLowB: push_decoded(escd_pkg::CodeBackspc, 1'b0);
                  escd_pkg::ChLowF: push_decoded(escd_pkg::CodeFormfeed, 1'b0);
                  escd_pkg::ChLowN: push_decoded(escd_pkg::CodeNewline, 1'b0);
                  escd_pkg::ChLowR: push_decoded(escd_pkg::CodeReturn, 1'b0);
                  escd_pkg::ChLowT: push_decoded(escd_pkg::CodeTab, 1'b0);
                  escd_pkg::ChLowV: push_decoded(escd_pkg::CodeVtab, 1'b0);
                  escd_pkg::ChQuote, escd_pkg::ChDquote, escd_pkg::ChBackslash: begin
                     push_decoded(b, 1'b0);
                  end
                  escd_pkg::ChLowX: begin
                     if (last) begin
                        push_decoded(8'h00, 1'b1);
                     end else begin
                        dec_mode = DEC_HEX0;
                     end
                  end
                  default: begin
                     if (is_oct_digit(b)) begin
                        oct_acc = {6'd0, b[2:0]};
                        oct_cnt = 2'd1;
                        if (last) begin
                           push_decoded(oct_acc[7:0], 1'b0);
                        end else begin
                           dec_mode = DEC_OCT;
                        end
                     end else begin
                        push_decoded(escd_pkg::ChBackslash, 1'b0);
                        push_decoded(b, 1'b0);
                     end
                  end
               endcase
            end
            DEC_OCT: begin
               if (is_oct_digit(b) && oct_cnt < 2'd3) begin
                  oct_acc = {oct_acc[5:0], b[2:0]};
                  oct_cnt = oct_cnt + 2'd1;
                  if (oct_cnt == 2'd3 || last) begin
                     push_decoded(oct_acc[7:0], 1'b0);
                     dec_mode = DEC_TEXT;
                  end
               end else begin
                  // The run is cut short: its value first, then the byte as text.
                  push_decoded(oct_acc[7:0], 1'b0);
                  dec_mode = DEC_TEXT;
                  decode_text(b, last);
               end
            end
            DEC_HEX0: begin
               hv = hex_nibble(b);
               if (hv[4] && !last) begin
                  hex_held = b;
                  dec_mode = DEC_HEX1;
               end else begin
                  push_decoded(8'h00, 1'b1);
                  dec_mode = DEC_TEXT;
                  decode_text(b, last);
               end
            end
            DEC_HEX1: begin
               hv = hex_nibble(b);
               if (hv[4]) begin
                  hh = hex_nibble(hex_held);
                  push_decoded({hh[3:0], hv[3:0]}, 1'b0);
                  dec_mode = DEC_TEXT;
               end else begin
                  // Short escape: error, then the held digit, then this byte as text.
                  push_decoded(8'h00, 1'b1);
                  push_decoded(hex_held, 1'b0);
                  dec_mode = DEC_TEXT;
                  decode_text(b, last);
               end
            end
            default: begin
               dec_mode = DEC_TEXT;
               decode_text(b, last);
            end
         endcase
      end

      if (dec_mode != DEC_OCT) begin
         oct_acc = '0;
         oct_cnt = '0;
      end
      if (dec_mode != DEC_HEX1) begin
         hex_held = '0;
      end
      if (last) begin
         dec_mode = DEC_TEXT;
         oct_acc  = '0;
         oct_cnt  = '0;
         hex_held = '0;
      end

      if (step_res.size() != 0) begin
         step_res[step_res.size() - 1].run_last   = 1'b1;
         step_res[step_res.size() - 1].string_end = last;
      end
      foreach (step_res[i]) decoded_q.push_back(step_res[i]);
   endfunction

   task automatic check_field(input string fname, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         fail_cnt++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      end
   endtask

   // Drive the next input word at the falling edge and pick the result stall.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_hs) begin
            if (lit_bytes_q.size() != 0 && $urandom_range(0, 99) >= stall_pct) begin
               req_valid   <= 1'b1;
               req_in_byte <= lit_bytes_q[0].data;
               req_in_last <= lit_bytes_q[0].last;
               lit_bytes_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Sample both channels at the rising edge: predict on input, check on output.
   always @(posedge clock) begin
      if (reset) begin
         req_hs   <= 1'b0;
         dec_mode = DEC_TEXT;
         oct_acc  = '0;
         oct_cnt  = '0;
         hex_held = '0;
         raw_q    = 1'b0;
         wd_cnt   = 0;
      end else begin
         req_hs <= req_valid && req_ready;
         if (csr_wr_en) raw_q = csr_raw_mode;
         if (req_valid && req_ready) begin
            n_accepted++;
            decode_word(req_in_byte, req_in_last);
         end
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               fail_cnt++;
               $display("%0t: result with nothing expected, actual byte %0h err %b",
                        $time, rsp_out_byte, rsp_is_error);
            end else begin
               check_field("out_byte", decoded_q[0].out_byte, rsp_out_byte);
               check_field("is_error", decoded_q[0].is_error, rsp_is_error);
               check_field("run_last", decoded_q[0].run_last, rsp_run_last);
               check_field("string_end", decoded_q[0].string_end, rsp_string_end);
               decoded_q.pop_front();
            end
            n_checked++;
            if (rsp_is_error) n_err_res++;
            if (rsp_string_end) n_str_end++;
         end
         // The watchdog restarts whenever either channel moves a word.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            wd_cnt = 0;
         end else begin
            wd_cnt++;
         end
         if (wd_cnt >= WdLimit) begin
            $display("%0t: watchdog expired, %0d results still expected", $time,
                     decoded_q.size());
            $display("string_escape_decoder_core_tb: done, errors");
            $finish;
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic last);
      lit_byte_type w;
      w.data = b;
      w.last = last;
      lit_bytes_q.push_back(w);
      n_queued++;
   endtask

   function automatic logic [7:0] rand_oct();
      return escd_pkg::ChZero + 8'($urandom_range(0, 7));
   endfunction

   function automatic logic [7:0] rand_hex();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return escd_pkg::ChZero + 8'(v);
      return ($urandom_range(0, 1) ? escd_pkg::ChLowA : escd_pkg::ChUpA) + 8'(v - 10);
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] c;
      logic [4:0] hv;
      c  = 8'($urandom_range(0, 255));
      hv = hex_nibble(c);
      if (hv[4]) c = escd_pkg::ChLowF + 8'd1 + 8'($urandom_range(0, 19));
      return c;
   endfunction

   // One literal with random escapes, some of them malformed, sometimes ending inside one.
   task automatic add_literal();
      logic [7:0] body[$];
      logic [7:0] c;
      logic [7:0] named_esc[10];
      named_esc = '{escd_pkg::ChLowA, escd_pkg::ChLowB, escd_pkg::ChLowF,
                    escd_pkg::ChLowN, escd_pkg::ChLowR, escd_pkg::ChLowT,
                    escd_pkg::ChLowV, escd_pkg::ChQuote, escd_pkg::ChDquote,
                    escd_pkg::ChBackslash};
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 9))
            2: begin
               body.push_back(escd_pkg::ChBackslash);
               body.push_back(named_esc[$urandom_range(0, 9)]);
            end
            3: begin
               body.push_back(escd_pkg::ChBackslash);
               repeat ($urandom_range(1, 3)) body.push_back(rand_oct());
            end
            4: begin
               body.push_back(escd_pkg::ChBackslash);
               body.push_back(escd_pkg::ChLowX);
               body.push_back(rand_hex());
               body.push_back(rand_hex());
            end
            5: begin
               body.push_back(escd_pkg::ChBackslash);
               body.push_back(escd_pkg::ChLowX);
               if ($urandom_range(0, 1)) body.push_back(rand_hex());
               body.push_back(rand_non_hex());
            end
            6: begin
               body.push_back(escd_pkg::ChBackslash);
               body.push_back(8'($urandom_range(0, 255)));
            end
            7: begin
               body.push_back(escd_pkg::ChBackslash);
               body.push_back(escd_pkg::ChNewline);
            end
            8: body.push_back(8'($urandom_range(0, 255)));
            default: begin
               c = 8'($urandom_range(0, 255));
               if (c == escd_pkg::ChBackslash) c = escd_pkg::ChLowA;
               body.push_back(c);
            end
         endcase
      end
      case ($urandom_range(0, 7))
         0: body.push_back(escd_pkg::ChBackslash);
         1: begin
            body.push_back(escd_pkg::ChBackslash);
            body.push_back(escd_pkg::ChLowX);
         end
         2: begin
            body.push_back(escd_pkg::ChBackslash);
            body.push_back(escd_pkg::ChLowX);
            body.push_back(rand_hex());
         end
         3: begin
            body.push_back(escd_pkg::ChBackslash);
            body.push_back(rand_oct());
         end
         4: begin
            body.push_back(escd_pkg::ChBackslash);
            body.push_back(rand_oct());
            body.push_back(rand_oct());
         end
         default: ;
      endcase
      foreach (body[i]) queue_byte(body[i], i == body.size() - 1);
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 4)) begin
         queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic add_random(input int count);
      int target;
      target = n_queued + count;
      while (n_queued < target) begin
         if ($urandom_range(0, 7) == 0) add_noise();
         else add_literal();
      end
   endtask

   // Wait until every queued word is in and every expected result is out.
   task automatic wait_idle();
      while (n_accepted != n_queued || decoded_q.size() != 0) @(negedge clock);
      repeat (DrainWait) @(negedge clock);
   endtask

   task automatic write_raw(input logic v);
      @(negedge clock);
      csr_wr_en    <= 1'b1;
      csr_raw_mode <= v;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_raw(1'b0);

      // Directed words: field extremes, escape kinds and the awkward endings.
      queue_byte(8'hFF, 1'b0);
      queue_byte(escd_pkg::ChBackslash, 1'b0);
      queue_byte(escd_pkg::ChDquote, 1'b0);
      // Backslash-newline closing the literal gives no result at all.
      queue_byte(escd_pkg::ChBackslash, 1'b0);
      queue_byte(escd_pkg::ChNewline, 1'b1);
      queue_byte(escd_pkg::ChBackslash, 1'b0);
      queue_byte(escd_pkg::ChZero + 8'd1, 1'b0);
      queue_byte(escd_pkg::ChZero + 8'd2, 1'b0);
      queue_byte(escd_pkg::ChSeven, 1'b0);
      // Octal run cut short by a non-octal digit.
      queue_byte(escd_pkg::ChBackslash, 1'b0);
      queue_byte(escd_pkg::ChSeven, 1'b0);
      queue_byte(escd_pkg::ChZero + 8'd8, 1'b0);
      // Octal run closed by the last byte.
      queue_byte(escd_pkg::ChBackslash, 1'b0);
      queue_byte(escd_pkg::ChZero + 8'd4, 1'b1);
      queue_byte(escd_pkg::ChBackslash, 1'b0);
      queue_byte(escd_pkg::ChLowX, 1'b0);
      queue_byte(escd_pkg::ChZero + 8'd4, 1'b0);
      queue_byte(escd_pkg::ChUpF, 1'b0);
      // Short hex escapes, mid-literal and at the last byte.
      queue_byte(escd_pkg::ChBackslash, 1'b0);
      queue_byte(escd_pkg::ChLowX, 1'b0);
      queue_byte(escd_pkg::ChLowF + 8'd1, 1'b0);
      queue_byte(escd_pkg::ChBackslash, 1'b0);
      queue_byte(escd_pkg::ChLowX, 1'b0);
      queue_byte(escd_pkg::ChZero + 8'd5, 1'b1);
      // Unknown escape, then a lone trailing backslash.
      queue_byte(escd_pkg::ChBackslash, 1'b0);
      queue_byte(escd_pkg::ChLowX + 8'd2, 1'b0);
      queue_byte(escd_pkg::ChBackslash, 1'b1);
      queue_byte(8'h00, 1'b1);
      // Leave an escape open so that raw mode has one to drop.
      queue_byte(escd_pkg::ChBackslash, 1'b0);
      wait_idle();

      // Raw mode: everything passes through unchanged.
      write_raw(1'b1);
      queue_byte(escd_pkg::ChLowN, 1'b0);
      queue_byte(escd_pkg::ChBackslash, 1'b0);
      repeat (20) queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      wait_idle();

      // Decoding with neither side stalling.
      write_raw(1'b0);
      stall_pct = 0;
      add_random(40);
      wait_idle();

      // Decoding with random stalls on both sides.
      stall_pct = 20;
      add_random(60);
      queue_byte(escd_pkg::ChBackslash, 1'b0);
      wait_idle();

      write_raw(1'b1);
      repeat (10) queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      wait_idle();

      write_raw(1'b0);
      add_random(15);
      wait_idle();

      $display("Sent %0d input words through decode and raw modes; %0d results checked,",
               n_accepted, n_checked);
      $display("among them %0d hex escape errors and %0d literal ends.", n_err_res,
               n_str_end);
      if (fail_cnt == 0) begin
         $display("string_escape_decoder_core_tb: done, clean");
      end else begin
         $display("string_escape_decoder_core_tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/escd_pkg.sv
hw/rtl/escd_front.sv
hw/rtl/escd_queue.sv
hw/rtl/escd_back.sv
hw/rtl/string_escape_decoder_core.sv
dv/string_escape_decoder_core_tb.sv
